>>> hw/rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Types, table contents and microcode encodings for the thermistor converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int ROM_POINTS = 33;
    localparam int IDX_W      = 6;
    localparam int XW         = 32;
    localparam int YW         = 19;
    localparam int QW         = 16;
    localparam int CNT_W      = 5;
    localparam int PC_W       = 4;
    localparam int THR_LSB    = 4;
    localparam int THR_MSB    = 11;
    localparam int ADC_HI_W   = 4;
    localparam int MASK_W     = 8;

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QW);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [PC_W-1:0]  t_pc;

    // voltage codes, falling with the index
    localparam logic signed [YW-1:0] VOLT_ROM [ROM_POINTS] = '{
        19'sh00F8D, 19'sh00F6A, 19'sh00F29, 19'sh00EE4, 19'sh00E9D, 19'sh00E3F,
        19'sh00DBF, 19'sh00D33, 19'sh00C97, 19'sh00BF5, 19'sh00B3A, 19'sh00A42,
        19'sh007F1, 19'sh00734, 19'sh0066B, 19'sh005A3, 19'sh004EE, 19'sh00446,
        19'sh0043A, 19'sh00430, 19'sh003C3, 19'sh003BD, 19'sh0033B, 19'sh002BB,
        19'sh00259, 19'sh00206, 19'sh001CE, 19'sh00191, 19'sh00160, 19'sh0012E,
        19'sh000F9, 19'sh000D7, 19'sh0009F
    };

    // millidegrees, rising with the index
    localparam logic signed [YW-1:0] TEMP_ROM [ROM_POINTS] = '{
        -19'sd26428, -19'sd21922, -19'sd15958, -19'sd11060, -19'sd6890,
        -19'sd2264,   19'sd2961,   19'sd7818,   19'sd12525,  19'sd16945,
         19'sd21623,  19'sd27431,  19'sd40631,  19'sd44960,  19'sd49757,
         19'sd54854,  19'sd59898,  19'sd65076,  19'sd65779,  19'sd65856,
         19'sd69654,  19'sd69873,  19'sd74910,  19'sd80691,  19'sd85844,
         19'sd90915,  19'sd94873,  19'sd99720,  19'sd104216, 19'sd109531,
         19'sd116445, 19'sd121600, 19'sd131839
    };

    typedef enum logic [3:0] {
        U_WAIT,
        U_CHECK,
        U_CLAMP_LO,
        U_CLAMP_HI,
        U_SEARCH_INIT,
        U_SEARCH,
        U_SEGMENT,
        U_MUL,
        U_DIV,
        U_ADD,
        U_OUT,
        U_NOP
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_IN_IDLE,
        C_DISABLED,
        C_CLAMP_LO,
        C_CLAMP_HI,
        C_SEARCH_GO,
        C_CNT_MORE,
        C_OUT_BUSY,
        C_ALWAYS
    } t_cond;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic disabled;
        logic clamp_lo;
        logic clamp_hi;
        logic search_go;
        logic cnt_more;
        logic out_busy;
    } t_flags;

endpackage

>>> hw/rtl/ntc_seq.sv
// ----------------------------------------------------------------------------
// ntc_seq
// Microcode store and step counter; issues one micro-op per cycle.
// ----------------------------------------------------------------------------
module ntc_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ntc_pkg::t_flags i_flags,
    output ntc_pkg::t_uop o_uop
);
    import ntc_pkg::*;

    localparam t_pc PcWait   = 4'd0;
    localparam t_pc PcSearch = 4'd5;
    localparam t_pc PcDiv    = 4'd8;
    localparam t_pc PcOut    = 4'd10;

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl ctrl;
    logic  take;

    // program store
    always_comb begin
        case (r_pc)
            4'd0:    ctrl = '{uop: U_WAIT,        cond: C_IN_IDLE,   target: PcWait};
            4'd1:    ctrl = '{uop: U_CHECK,       cond: C_DISABLED,  target: PcOut};
            4'd2:    ctrl = '{uop: U_CLAMP_LO,    cond: C_CLAMP_LO,  target: PcOut};
            4'd3:    ctrl = '{uop: U_CLAMP_HI,    cond: C_CLAMP_HI,  target: PcOut};
            4'd4:    ctrl = '{uop: U_SEARCH_INIT, cond: C_NEVER,     target: PcWait};
            4'd5:    ctrl = '{uop: U_SEARCH,      cond: C_SEARCH_GO, target: PcSearch};
            4'd6:    ctrl = '{uop: U_SEGMENT,     cond: C_NEVER,     target: PcWait};
            4'd7:    ctrl = '{uop: U_MUL,         cond: C_NEVER,     target: PcWait};
            4'd8:    ctrl = '{uop: U_DIV,         cond: C_CNT_MORE,  target: PcDiv};
            4'd9:    ctrl = '{uop: U_ADD,         cond: C_NEVER,     target: PcWait};
            4'd10:   ctrl = '{uop: U_OUT,         cond: C_OUT_BUSY,  target: PcOut};
            default: ctrl = '{uop: U_NOP,         cond: C_ALWAYS,    target: PcWait};
        endcase
    end

    always_comb begin
        case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_IN_IDLE:   take = !i_flags.in_valid;
            C_DISABLED:  take = i_flags.disabled;
            C_CLAMP_LO:  take = i_flags.clamp_lo;
            C_CLAMP_HI:  take = i_flags.clamp_hi;
            C_SEARCH_GO: take = i_flags.search_go;
            C_CNT_MORE:  take = i_flags.cnt_more;
            C_OUT_BUSY:  take = i_flags.out_busy;
            C_ALWAYS:    take = 1'b1;
            default:     take = 1'b0;
        endcase
    end

    assign n_pc  = take ? ctrl.target : r_pc + t_pc'(1);
    assign o_uop = ctrl.uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PcWait;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> hw/rtl/ntc_adc_temperature_converter.sv
// sequence: a disabled channel goes from the check to the output, an input beyond a
// table end through the clamp steps, an interpolated value through search, segment,
// multiply, 16-step bit-serial divide and add; one item at a time, the next input
// taken only once the result is loaded into the output register
// reset: synchronous, active low; clears the channel enable mask to 0, the
// step counter and the result valid
// ----------------------------------------------------------------------------
// ntc_adc_temperature_converter
// Thermistor ADC code to temperature and trip temperature to threshold byte,
// by piecewise linear interpolation over a fixed table.
// ----------------------------------------------------------------------------
module ntc_adc_temperature_converter #(
    parameter int TABLE_ENTRIES = 33,
    parameter int CHANNELS      = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ntc_pkg::MASK_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [2:0]                      i_channel,
    input  logic [7:0]                      i_adc_low_byte,
    input  logic [7:0]                      i_adc_high_byte,
    input  logic signed [31:0]              i_trip_temp,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output logic signed [18:0]              o_temperature,
    output logic [7:0]                      o_threshold_byte,
    output logic [2:0]                      o_channel_out
);
    import ntc_pkg::*;

    localparam int UsedPoints = (TABLE_ENTRIES < ROM_POINTS) ? TABLE_ENTRIES : ROM_POINTS;
    localparam t_idx LastIdx = IDX_W'(UsedPoints - 1);
    localparam logic [3:0] ChanLimit = 4'(CHANNELS);

    function automatic logic signed [YW-1:0] tab_x(input logic op, input t_idx idx);
        return op ? TEMP_ROM[idx] : VOLT_ROM[idx];
    endfunction

    function automatic logic signed [YW-1:0] tab_y(input logic op, input t_idx idx);
        return op ? VOLT_ROM[idx] : TEMP_ROM[idx];
    endfunction

    function automatic logic signed [XW-1:0] sx(input logic signed [YW-1:0] v);
        return {{(XW-YW){v[YW-1]}}, v};
    endfunction

    t_uop   uop;
    t_flags flags;

    logic [MASK_W-1:0]     r_mask;
    logic                  r_op;
    logic [2:0]            r_chan;
    logic signed [XW-1:0]  r_x;
    logic                  r_status;
    logic signed [YW-1:0]  r_y;
    logic signed [YW-1:0]  r_ybase;
    t_idx                  r_lo;
    t_idx                  r_hi;
    logic [QW-1:0]         r_dy;
    logic [QW-1:0]         r_n;
    logic [QW-1:0]         r_d;
    logic [QW-1:0]         r_rem;
    logic [QW-1:0]         r_quo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_o_valid;
    logic                  r_o_status;
    logic signed [YW-1:0]  r_o_temp;
    logic [7:0]            r_o_thr;
    logic [2:0]            r_o_chan;

    logic                  enabled;
    logic [IDX_W:0]        mid_sum;
    t_idx                  mid;
    logic signed [XW-1:0]  tx_mid;
    logic signed [XW-1:0]  tx_first;
    logic signed [XW-1:0]  tx_last;
    logic                  hit_mid;
    t_idx                  prev_idx;
    logic signed [YW-1:0]  x_i;
    logic signed [YW-1:0]  x_p;
    logic signed [YW-1:0]  y_i;
    logic signed [YW-1:0]  y_p;
    logic signed [YW:0]    dx_full;
    logic signed [YW:0]    dy_full;
    logic signed [XW:0]    n_full;
    logic [2*QW-1:0]       prod;
    logic [QW:0]           div_shift;
    logic [QW+1:0]         div_diff;
    logic                  div_take;
    logic signed [YW-1:0]  quo_ext;
    logic                  out_load;

    ntc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    assign o_ready     = (uop == U_WAIT);
    assign o_cfg_ready = 1'b1;

    assign enabled = ({1'b0, r_chan} < ChanLimit) && r_mask[r_chan];

    // binary search probe
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IDX_W:1];
    assign tx_mid  = sx(tab_x(r_op, mid));
    assign hit_mid = r_op ? (tx_mid >= r_x) : (tx_mid <= r_x);

    assign tx_first = sx(tab_x(r_op, '0));
    assign tx_last  = sx(tab_x(r_op, LastIdx));

    // segment operands; the three differences are taken as magnitudes when registered
    assign prev_idx = r_lo - t_idx'(1);
    assign x_i      = tab_x(r_op, r_lo);
    assign x_p      = tab_x(r_op, prev_idx);
    assign y_i      = tab_y(r_op, r_lo);
    assign y_p      = tab_y(r_op, prev_idx);
    assign dx_full  = (YW+1)'(x_p) - (YW+1)'(x_i);
    assign dy_full  = (YW+1)'(y_p) - (YW+1)'(y_i);
    assign n_full   = (XW+1)'(r_x) - (XW+1)'(sx(x_i));

    assign prod = r_dy * r_n;

    // restoring divide, one quotient bit per step
    assign div_shift = {r_rem, r_quo[QW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, r_d};
    assign div_take  = !div_diff[QW+1];

    assign quo_ext = signed'({{(YW-QW){1'b0}}, r_quo});

    assign out_load = (uop == U_OUT) && !flags.out_busy;

    always_comb begin
        flags.in_valid  = i_valid;
        flags.disabled  = !r_op && !enabled;
        flags.clamp_lo  = r_op ? (tx_first >= r_x) : (tx_first <= r_x);
        flags.clamp_hi  = r_op ? (r_x >= tx_last) : (r_x <= tx_last);
        flags.search_go = (r_lo != r_hi);
        flags.cnt_more  = (r_cnt != CNT_W'(1));
        flags.out_busy  = r_o_valid && !i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (uop)
            U_WAIT: begin
                if (i_valid) begin
                    r_op   <= i_op;
                    r_chan <= i_channel;
                    if (i_op) begin
                        r_x <= i_trip_temp;
                    end else begin
                        r_x <= signed'({{(XW-12){1'b0}}, i_adc_high_byte[ADC_HI_W-1:0],
                                        i_adc_low_byte});
                    end
                end
            end
            U_CHECK: begin
                r_status <= flags.disabled;
                r_y      <= '0;
            end
            U_CLAMP_LO: begin
                if (flags.clamp_lo) begin
                    r_y <= tab_y(r_op, '0);
                end
            end
            U_CLAMP_HI: begin
                if (flags.clamp_hi) begin
                    r_y <= tab_y(r_op, LastIdx);
                end
            end
            U_SEARCH_INIT: begin
                r_lo <= t_idx'(1);
                r_hi <= LastIdx;
            end
            U_SEARCH: begin
                if (flags.search_go) begin
                    if (hit_mid) begin
                        r_hi <= mid;
                    end else begin
                        r_lo <= mid + t_idx'(1);
                    end
                end
            end
            U_SEGMENT: begin
                r_ybase <= y_i;
                r_d     <= dx_full[YW] ? QW'(-dx_full) : QW'(dx_full);
                r_dy    <= dy_full[YW] ? QW'(-dy_full) : QW'(dy_full);
                r_n     <= n_full[XW] ? QW'(-n_full) : QW'(n_full);
            end
            U_MUL: begin
                r_rem <= prod[2*QW-1:QW];
                r_quo <= prod[QW-1:0];
                r_cnt <= DIV_STEPS;
            end
            U_DIV: begin
                r_rem <= div_take ? div_diff[QW-1:0] : div_shift[QW-1:0];
                r_quo <= {r_quo[QW-2:0], div_take};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            U_ADD: begin
                // temperature falls toward the segment start, code rises
                r_y <= r_op ? (r_ybase + quo_ext) : (r_ybase - quo_ext);
            end
            U_OUT: begin
                if (out_load) begin
                    r_o_status <= r_status;
                    r_o_temp   <= r_op ? '0 : r_y;
                    r_o_thr    <= r_op ? r_y[THR_MSB:THR_LSB] : '0;
                    r_o_chan   <= r_chan;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_temperature    = r_o_temp;
    assign o_threshold_byte = r_o_thr;
    assign o_channel_out    = r_o_chan;

endmodule

>>> hw/rtl/ntc_chk.sv
// ----------------------------------------------------------------------------
// ntc_chk
// Port-level checks for the thermistor converter, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_status,
    input logic signed [18:0] o_temperature,
    input logic [7:0]         o_threshold_byte,
    input logic [2:0]         o_channel_out
);

    // result stays offered until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_temperature) && $stable(o_threshold_byte)
                                && $stable(o_status) && $stable(o_channel_out))
        else $error("result changed while stalled");

    // one item in flight: input closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while an item is in flight");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> (o_temperature == 19'sd0) && (o_threshold_byte == 8'd0))
        else $error("disabled channel carries a value");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature == 19'sd0) || (o_threshold_byte == 8'd0))
        else $error("temperature and threshold both set");

endmodule

bind ntc_adc_temperature_converter ntc_chk u_ntc_chk (.*);
